### rtl/core/brfd_pkg.sv
// Shared constants, types and the CRC-16/CCITT-FALSE byte update for the
// batched request frame deframer.
// No dependencies; every other file refers to this package by scoped names.
package brfd_pkg;

	// Frame limits.
	localparam int MAX_REQUESTS = 256;
	localparam int TXID_BYTES   = 16;
	localparam int MIN_REQ_LEN  = 1 + TXID_BYTES;

	// Request index counts up to MAX_REQUESTS itself; the table address does not.
	localparam int IDX_W  = $clog2(MAX_REQUESTS + 1);
	localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Stream widths.
	localparam int TDATA_W = 56;
	localparam int TUSER_W = 4;

	// CRC seed and polynomial.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Byte roles.
	localparam logic [2:0] ROLE_COUNT   = 3'd0;
	localparam logic [2:0] ROLE_LENGTH  = 3'd1;
	localparam logic [2:0] ROLE_OPCODE  = 3'd2;
	localparam logic [2:0] ROLE_TXID    = 3'd3;
	localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
	localparam logic [2:0] ROLE_TRAIL   = 3'd5;

	// Frame status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_CRC   = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT = 3'd2;
	localparam logic [2:0] ST_TABLE_CUT = 3'd3;
	localparam logic [2:0] ST_REQ_SHORT = 3'd4;
	localparam logic [2:0] ST_OVERRUN   = 3'd5;
	localparam logic [2:0] ST_TOO_MANY  = 3'd6;

	// One result item as produced by the parser.
	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  body_byte;
		logic [2:0]  byte_role;
		logic [7:0]  request_number;
		logic [15:0] offset_in_request;
		logic        frame_done;
		logic [2:0]  frame_status;
		logic [15:0] declared_requests;
	} result_t;

	// MSB-first CRC update over one byte.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/core/brfd_parser.sv
// Frame parser: two-byte CRC hold-back, CRC, field tracking, length table
// memory and end-of-frame status. Depends on brfd_pkg.
// All state advances by one byte per cycle when step is high.
module brfd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               res_valid,
	output brfd_pkg::result_t  res
);

	typedef enum logic [1:0] {
		PH_COUNT,
		PH_LENGTHS,
		PH_REQUESTS,
		PH_TRAILING
	} phase_t;

	// Frame state.
	logic [7:0]          delay0_q, delay1_q;
	logic [1:0]          seen_q;
	logic [15:0]         crc_q;
	phase_t              phase_q;
	logic [15:0]         total_q;
	brfd_pkg::idx_t      item_q;
	logic [15:0]         bii_q;
	logic [7:0]          hold_q;
	logic                short_vld_q;
	brfd_pkg::idx_t      short_idx_q;
	logic                ovf_q;
	// Length of the request being parsed, entry 0 and the prefetched next entry.
	logic [15:0]         cur_len_q;
	logic [15:0]         entry0_q;
	logic [15:0]         next_len_q;

	logic [15:0]         len_table [brfd_pkg::MAX_REQUESTS];

	// Next-state values.
	logic [7:0]          delay0_d, delay1_d;
	logic [1:0]          seen_d;
	logic [15:0]         crc_d;
	phase_t              phase_d;
	logic [15:0]         total_d;
	brfd_pkg::idx_t      item_d;
	logic [15:0]         bii_d;
	logic [7:0]          hold_d;
	logic                short_vld_d;
	brfd_pkg::idx_t      short_idx_d;
	logic                ovf_d;
	logic [15:0]         cur_len_d;

	logic                released;
	logic [7:0]          rel;
	logic [15:0]         word;
	brfd_pkg::idx_t      item_inc;
	logic [15:0]         bii_inc;
	logic                tbl_we;
	brfd_pkg::addr_t     tbl_waddr;
	brfd_pkg::addr_t     tbl_raddr;
	logic [2:0]          status;
	logic [15:0]         expect_crc;

	assign released = (seen_q >= 2'd2);
	assign rel      = delay0_q;
	assign word     = {hold_q, rel};
	assign item_inc = item_q + 1'b1;
	assign bii_inc  = bii_q + 16'd1;

	// Parse the byte leaving the hold-back and work out the next state.
	always_comb begin
		delay0_d    = delay0_q;
		delay1_d    = delay1_q;
		seen_d      = seen_q;
		crc_d       = crc_q;
		phase_d     = phase_q;
		total_d     = total_q;
		item_d      = item_q;
		bii_d       = bii_q;
		hold_d      = hold_q;
		short_vld_d = short_vld_q;
		short_idx_d = short_idx_q;
		ovf_d       = ovf_q;
		cur_len_d   = cur_len_q;
		tbl_we      = 1'b0;
		res         = '0;

		if (released) begin
			res.byte_valid = 1'b1;
			res.body_byte  = rel;
			crc_d          = brfd_pkg::crc_byte(crc_q, rel);
			case (phase_q)
				PH_COUNT: begin
					res.byte_role         = brfd_pkg::ROLE_COUNT;
					res.offset_in_request = bii_q;
					if (bii_q == 16'd0) begin
						hold_d = rel;
						bii_d  = 16'd1;
					end else begin
						total_d = word;
						item_d  = '0;
						bii_d   = 16'd0;
						if (word > 16'(brfd_pkg::MAX_REQUESTS)) begin
							ovf_d   = 1'b1;
							phase_d = PH_TRAILING;
						end else if (word == 16'd0) begin
							phase_d = PH_TRAILING;
						end else begin
							phase_d = PH_LENGTHS;
						end
					end
				end
				PH_LENGTHS: begin
					res.byte_role         = brfd_pkg::ROLE_LENGTH;
					res.request_number    = 8'(item_q);
					res.offset_in_request = bii_q;
					if (bii_q == 16'd0) begin
						hold_d = rel;
						bii_d  = 16'd1;
					end else begin
						tbl_we = 1'b1;
						bii_d  = 16'd0;
						if (word < 16'(brfd_pkg::MIN_REQ_LEN) && !short_vld_q) begin
							short_vld_d = 1'b1;
							short_idx_d = item_q;
						end
						if (16'(item_inc) >= total_q) begin
							// Table complete: move on to request 0, or to the trailing bytes if its length is zero.
							item_d    = '0;
							cur_len_d = (item_q == '0) ? word : entry0_q;
							phase_d   = (cur_len_d == 16'd0) ? PH_TRAILING : PH_REQUESTS;
						end else begin
							item_d = item_inc;
						end
					end
				end
				PH_REQUESTS: begin
					if (bii_q == 16'd0) begin
						res.byte_role = brfd_pkg::ROLE_OPCODE;
					end else if (bii_q <= 16'(brfd_pkg::TXID_BYTES)) begin
						res.byte_role = brfd_pkg::ROLE_TXID;
					end else begin
						res.byte_role = brfd_pkg::ROLE_PAYLOAD;
					end
					res.request_number    = 8'(item_q);
					res.offset_in_request = bii_q;
					if (bii_inc >= cur_len_q) begin
						item_d    = item_inc;
						bii_d     = 16'd0;
						cur_len_d = next_len_q;
						if (16'(item_inc) >= total_q || next_len_q == 16'd0) begin
							phase_d = PH_TRAILING;
						end else begin
							phase_d = PH_REQUESTS;
						end
					end else begin
						bii_d = bii_inc;
					end
				end
				default: begin
					res.byte_role = brfd_pkg::ROLE_TRAIL;
				end
			endcase
			delay0_d = delay1_q;
			delay1_d = data_byte;
			seen_d   = 2'd3;
		end else if (seen_q == 2'd0) begin
			delay0_d = data_byte;
			seen_d   = 2'd1;
		end else begin
			delay1_d = data_byte;
			seen_d   = 2'd2;
		end

		res.declared_requests = total_d;

		// End-of-frame status, from the state after this byte.
		expect_crc = {delay0_d, delay1_d};
		if (seen_d < 2'd2) begin
			status = brfd_pkg::ST_TOO_SHORT;
		end else if (expect_crc != crc_d) begin
			status = brfd_pkg::ST_BAD_CRC;
		end else if (phase_d == PH_COUNT) begin
			status = brfd_pkg::ST_TOO_SHORT;
		end else if (ovf_d) begin
			status = brfd_pkg::ST_TOO_MANY;
		end else if (phase_d == PH_LENGTHS) begin
			status = brfd_pkg::ST_TABLE_CUT;
		end else if (phase_d == PH_REQUESTS && (!short_vld_d || item_d <= short_idx_d)) begin
			status = brfd_pkg::ST_OVERRUN;
		end else if (short_vld_d) begin
			status = brfd_pkg::ST_REQ_SHORT;
		end else begin
			status = brfd_pkg::ST_OK;
		end

		if (last_byte) begin
			res.frame_done   = 1'b1;
			res.frame_status = status;
		end
	end

	assign res_valid = released || last_byte;

	// Frame state registers; everything returns to reset after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay0_q    <= '0;
			delay1_q    <= '0;
			seen_q      <= '0;
			crc_q       <= brfd_pkg::CRC_INIT;
			phase_q     <= PH_COUNT;
			total_q     <= '0;
			item_q      <= '0;
			bii_q       <= '0;
			hold_q      <= '0;
			short_vld_q <= 1'b0;
			short_idx_q <= '0;
			ovf_q       <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				delay0_q    <= '0;
				delay1_q    <= '0;
				seen_q      <= '0;
				crc_q       <= brfd_pkg::CRC_INIT;
				phase_q     <= PH_COUNT;
				total_q     <= '0;
				item_q      <= '0;
				bii_q       <= '0;
				hold_q      <= '0;
				short_vld_q <= 1'b0;
				short_idx_q <= '0;
				ovf_q       <= 1'b0;
			end else begin
				delay0_q    <= delay0_d;
				delay1_q    <= delay1_d;
				seen_q      <= seen_d;
				crc_q       <= crc_d;
				phase_q     <= phase_d;
				total_q     <= total_d;
				item_q      <= item_d;
				bii_q       <= bii_d;
				hold_q      <= hold_d;
				short_vld_q <= short_vld_d;
				short_idx_q <= short_idx_d;
				ovf_q       <= ovf_d;
			end
		end
	end

	// Length table: one write port, one registered read that prefetches the
	// entry after the next request index, with write-through on a clash.
	assign tbl_waddr = item_q[brfd_pkg::ADDR_W-1:0];
	assign tbl_raddr = brfd_pkg::addr_t'((step ? item_d : item_q) + 1'b1);

	always_ff @(posedge clk) begin
		if (step && tbl_we) begin
			len_table[tbl_waddr] <= word;
			if (item_q == '0) begin
				entry0_q <= word;
			end
		end
		if (step && tbl_we && tbl_waddr == tbl_raddr) begin
			next_len_q <= word;
		end else begin
			next_len_q <= len_table[tbl_raddr];
		end
		if (step) begin
			cur_len_q <= cur_len_d;
		end
	end

endmodule

### rtl/core/brfd_out_reg.sv
// Result register for the master-side stream: holds one result until it is
// transferred and packs it into tdata, tuser and tlast. Depends on brfd_pkg.
module brfd_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  brfd_pkg::result_t               res,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: body_byte, request_number, offset_in_request, frame_status,
	// declared_requests, zero padding
	output logic [brfd_pkg::TDATA_W-1:0]    m_axis_tdata,
	// tuser: byte_valid, byte_role
	output logic [brfd_pkg::TUSER_W-1:0]    m_axis_tuser,
	output logic                            m_axis_tlast
);

	logic              valid_q;
	brfd_pkg::result_t res_q;

	// Valid flag: set on load, cleared when the held result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = res_q.frame_done;
	assign m_axis_tuser  = {res_q.byte_role, res_q.byte_valid};
	assign m_axis_tdata  = {5'd0, res_q.declared_requests, res_q.frame_status,
		res_q.offset_in_request, res_q.request_number, res_q.body_byte};

endmodule

### rtl/core/batched_request_frame_deframer.sv
// Top level of the batched request frame deframer: input register, parser
// and result register. Depends on brfd_pkg, brfd_parser and brfd_out_reg.
//
// Usage: frame bytes arrive on the slave-side stream, one byte per transfer
// in tdata with tlast on the frame's final byte. The frame is a big-endian
// request count, a table of big-endian 16-bit request lengths, the requests
// and a big-endian CRC-16/CCITT-FALSE over the body. Each body byte leaves on
// the master-side stream tagged with its role, request number and offset;
// the two CRC bytes are held back and never emitted as body. The result for
// the frame's last byte has tlast set and carries the frame status.
// An input transfer is held in the input register, parsed, and its result
// registered in the result register. One byte per cycle is accepted while
// the receiver keeps up: the parser updates the CRC and all field counters
// together, and the length table is read one entry ahead. Bytes that cause
// no result (the first two bytes of a frame) leave the result register alone.
// Reset clears the frame state but not the request-length registers; the
// length table is not cleared, and only entries written earlier in the same
// frame are used. When the receiver stalls, the result register holds, the
// input register fills, and s_axis_tready drops until the result is sent.
module batched_request_frame_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: data_byte
	input  logic [7:0]                      s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: body_byte, request_number, offset_in_request, frame_status,
	// declared_requests, zero padding
	output logic [brfd_pkg::TDATA_W-1:0]    m_axis_tdata,
	// tuser: byte_valid, byte_role
	output logic [brfd_pkg::TUSER_W-1:0]    m_axis_tuser,
	output logic                            m_axis_tlast
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              advance;
	logic              res_valid;
	brfd_pkg::result_t res;

	// The held byte moves on when the result register is free or emptying.
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	brfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	brfd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_valid),
		.res           (res),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	// A result without a body byte is only ever the end-of-frame report.
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("result without body byte that is not frame end");

	// A status other than ok only appears on the frame's last result.
	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == brfd_pkg::ST_OK)
		else $error("frame status reported before frame end");

	// Without a body byte the tag fields stay clear.
	a_empty_tags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		m_axis_tuser[3:1] == brfd_pkg::ROLE_COUNT && m_axis_tdata[31:0] == 32'd0)
		else $error("tags set on a result without a body byte");

	// The parser never steps while the result register is full and stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !advance)
		else $error("result register overwritten while stalled");
`endif

endmodule
